// File: design/pps_pkg.sv
// pps_pkg: shared types, constants and codes of the pure pursuit steering block
// used by every module under design/ but pps_ram, depends on nothing

package pps_pkg;

  localparam int PATH_DEPTH_DEF = 1024;
  localparam int CFG_W          = 24;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANG   = 2'd2;

  localparam logic [CFG_W-1:0] LOOKAHEAD_RST = 24'd32768;
  localparam logic [CFG_W-1:0] MAX_LIN_RST   = 24'd19661;
  localparam logic [CFG_W-1:0] MAX_ANG_RST   = 24'd65536;

  // squared distances in units of 2^-32 m^2
  localparam logic [62:0] GOAL_D2_MAX = 63'd42949672;
  localparam logic [62:0] CURV_D2_MIN = 63'd4294967;

  // divider operand widths: |y| * gain * 2^17 over a 63-bit squared distance
  localparam int DIV_NUM_W = 72;
  localparam int DIV_DEN_W = 63;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_LOAD_FIRST,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] xa;   // point x or robot x
    logic signed [31:0] ya;   // point y or robot y
    logic signed [15:0] hc;
    logic signed [15:0] hs;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] lookahead;
    logic [CFG_W-1:0] max_lin;
    logic [CFG_W-1:0] max_ang;
  } cfg_t;

  typedef struct packed {
    logic [23:0]        linear;
    logic signed [31:0] angular;
    logic               goal;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIFF,
    ST_SQR,
    ST_GOAL,
    ST_ROT,
    ST_RND,
    ST_CSQ,
    ST_CURV,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

// File: design/pps_ram.sv
// pps_ram: generic single write port, single read port ram with registered read
// no dependencies

module pps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/pps_front.sv
// pps_front: accepts input items, classifies them into commands, two-entry queue
// depends on pps_pkg

module pps_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_user,
  input  logic [159:0]       in_data,
  output logic               q_valid,
  output pps_pkg::cmd_t      q_cmd,
  input  logic               q_pop
);
  import pps_pkg::*;

  cmd_t       fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd_in;
  logic       push, pop;

  always_comb begin
    cmd_in = '0;
    if (in_user[0]) begin
      cmd_in.kind = CMD_TICK;
      cmd_in.xa   = in_data[95:64];
      cmd_in.ya   = in_data[127:96];
      cmd_in.hc   = in_data[143:128];
      cmd_in.hs   = in_data[159:144];
    end else begin
      cmd_in.kind = in_user[1] ? CMD_LOAD_FIRST : CMD_LOAD;
      cmd_in.xa   = in_data[31:0];
      cmd_in.ya   = in_data[63:32];
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: design/pps_div.sv
// pps_div: restoring divider, one quotient bit a cycle, saturating signed result
// depends on pps_pkg

module pps_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pps_pkg::DIV_NUM_W-1:0] num,
  input  logic [pps_pkg::DIV_DEN_W-1:0] den,
  input  logic                          neg,
  output logic                          done,
  output logic signed [31:0]            quo
);
  import pps_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r, fin_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_NUM_W-1:0] n_r;
  logic [DIV_DEN_W-1:0] r_r, den_r, rnew;
  logic [32:0]          q_r, lim, sat;
  logic                 ovf_r, neg_r, ge;
  logic [DIV_DEN_W:0]   rs;

  always_comb begin
    rs   = {r_r, n_r[DIV_NUM_W-1]};
    ge   = (rs >= {1'b0, den_r});
    rnew = ge ? DIV_DEN_W'(rs - {1'b0, den_r}) : rs[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      r_r   <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      den_r <= den;
      neg_r <= neg;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_NUM_W-2:0], 1'b0};
      r_r   <= rnew;
      q_r   <= {q_r[31:0], ge};
      ovf_r <= ovf_r | q_r[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // saturate at 2^31 for a negative result, 2^31-1 otherwise
  always_comb begin
    lim = neg_r ? 33'h080000000 : 33'h07FFFFFFF;
    sat = (ovf_r || q_r >= lim) ? lim : q_r;
    quo = neg_r ? 32'(-sat) : sat[31:0];
  end

  assign done = fin_r;

endmodule

// File: design/pps_back.sv
// pps_back: path store, carrot scan pipeline and steering arithmetic
// depends on pps_pkg, pps_ram and pps_div

module pps_back #(
  parameter int PATH_DEPTH = pps_pkg::PATH_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pps_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  pps_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output pps_pkg::result_t res
);
  import pps_pkg::*;

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int LW = $clog2(PATH_DEPTH + 1);

  function automatic logic [30:0] clamp_abs(input logic signed [32:0] v);
    logic [32:0] a;
    a = v[32] ? 33'(-v) : 33'(v);
    return (a > 33'h07FFFFFFF) ? 31'h7FFFFFFF : a[30:0];
  endfunction

  // returns sign and clamped magnitude of v rounded from 2^-14 units
  function automatic logic [31:0] round14(input logic signed [49:0] v);
    logic [49:0] a;
    logic [50:0] r;
    logic [36:0] q;
    a = v[49] ? 50'(-v) : 50'(v);
    r = {1'b0, a} + 51'd8192;
    q = r[50:14];
    return {v[49], (q > 37'h07FFFFFFF) ? 31'h7FFFFFFF : q[30:0]};
  endfunction

  back_state_t state_r, state_nxt;

  logic [LW-1:0]      len_r, len_nxt, len_eff;
  logic signed [31:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic signed [15:0] hc_r, hc_nxt, hs_r, hs_nxt;
  logic [47:0]        l2_r, l2_nxt;

  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               issue_r, issue_nxt, first_r, first_nxt;
  logic               va_r, va_nxt, la_r, la_nxt;
  logic               vb_r, vb_nxt, lb_r, lb_nxt;
  logic               vc_r, vc_nxt, lc_r, lc_nxt;
  logic signed [31:0] bx_r, bx_nxt, by_r, by_nxt, cpx_r, cpx_nxt, cpy_r, cpy_nxt;
  logic [30:0]        bax_r, bax_nxt, bay_r, bay_nxt;
  logic [61:0]        sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic signed [31:0] car_x_r, car_x_nxt, car_y_r, car_y_nxt;

  logic signed [32:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [48:0] m1_r, m1_nxt, m2_r, m2_nxt, m3_r, m3_nxt, m4_r, m4_nxt;
  logic [30:0]        lxm_r, lxm_nxt, lym_r, lym_nxt;
  logic               lyn_r, lyn_nxt, goal_r, goal_nxt;
  logic [54:0]        p_r, p_nxt;
  logic signed [31:0] ang_r, ang_nxt;

  logic               res_valid_r, res_valid_nxt;
  result_t            res_r, res_nxt;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [63:0]        ram_rdata;
  logic [62:0]        dsum;
  logic               beyond, scan_done, is_load, out_free;
  logic signed [49:0] vx, vy;
  logic [31:0]        rnd_x, rnd_y;
  logic               div_start, div_done;
  logic signed [31:0] div_quo;

  pps_ram #(
    .WIDTH(64),
    .DEPTH(PATH_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({q_cmd.xa, q_cmd.ya}),
    .re   (ram_re),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  pps_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  ({p_r, 17'd0}),
    .den  (dsum),
    .neg  (lyn_r),
    .done (div_done),
    .quo  (div_quo)
  );

  assign dsum      = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign beyond    = dsum > {15'd0, l2_r};
  assign scan_done = vc_r && (!beyond || lc_r);
  assign is_load   = (q_cmd.kind != CMD_TICK);
  assign len_eff   = (q_cmd.kind == CMD_LOAD_FIRST) ? '0 : len_r;
  assign out_free  = !res_valid_r || res_ready;
  assign vx        = 50'(m1_r) + 50'(m2_r);
  assign vy        = 50'(m3_r) - 50'(m4_r);
  assign rnd_x     = round14(vx);
  assign rnd_y     = round14(vy);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && !is_load && len_r != '0) state_nxt = ST_SCAN;
      end
      ST_SCAN: if (scan_done) state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_GOAL;
      ST_GOAL: state_nxt = (dsum <= GOAL_D2_MAX) ? ST_OUT : ST_ROT;
      ST_ROT:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_CSQ;
      ST_CSQ:  state_nxt = ST_CURV;
      ST_CURV: state_nxt = (dsum > CURV_D2_MIN) ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    len_nxt = len_r;      rx_nxt = rx_r;        ry_nxt = ry_r;
    hc_nxt = hc_r;        hs_nxt = hs_r;        l2_nxt = l2_r;
    rd_idx_nxt = rd_idx_r; issue_nxt = 1'b0;    first_nxt = first_r;
    va_nxt = 1'b0;        la_nxt = rd_idx_r == '0;
    vb_nxt = 1'b0;        lb_nxt = la_r;
    vc_nxt = 1'b0;        lc_nxt = lb_r;
    bx_nxt = ram_rdata[63:32]; by_nxt = ram_rdata[31:0];
    bax_nxt = clamp_abs(33'($signed(ram_rdata[63:32])) - 33'(rx_r));
    bay_nxt = clamp_abs(33'($signed(ram_rdata[31:0])) - 33'(ry_r));
    cpx_nxt = bx_r;       cpy_nxt = by_r;
    sqx_nxt = bax_r * bax_r;
    sqy_nxt = bay_r * bay_r;
    car_x_nxt = car_x_r;  car_y_nxt = car_y_r;
    dx_nxt = dx_r;        dy_nxt = dy_r;
    m1_nxt = m1_r;        m2_nxt = m2_r;        m3_nxt = m3_r;     m4_nxt = m4_r;
    lxm_nxt = lxm_r;      lym_nxt = lym_r;      lyn_nxt = lyn_r;
    p_nxt = p_r;          ang_nxt = ang_r;      goal_nxt = goal_r;
    res_nxt = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    q_pop = 1'b0;
    ram_we = 1'b0;
    ram_waddr = len_eff[AW-1:0];
    ram_re = 1'b0;
    div_start = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (is_load) begin
            len_nxt = len_eff;
            if (len_eff < LW'(PATH_DEPTH)) begin
              ram_we  = 1'b1;
              len_nxt = len_eff + 1'b1;
            end
          end else if (len_r != '0) begin
            rx_nxt     = q_cmd.xa;
            ry_nxt     = q_cmd.ya;
            hc_nxt     = q_cmd.hc;
            hs_nxt     = q_cmd.hs;
            l2_nxt     = cfg.lookahead * cfg.lookahead;
            rd_idx_nxt = AW'(len_r - 1'b1);
            issue_nxt  = 1'b1;
            first_nxt  = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // reads issued from the last point down, three stages to the compare
        ram_re = issue_r;
        if (!scan_done) begin
          va_nxt = issue_r;
          vb_nxt = va_r;
          vc_nxt = vb_r;
          if (issue_r && rd_idx_r != '0) begin
            issue_nxt  = 1'b1;
            rd_idx_nxt = rd_idx_r - 1'b1;
          end
        end
        if (vc_r && (beyond || first_r)) begin
          car_x_nxt = cpx_r;
          car_y_nxt = cpy_r;
          first_nxt = 1'b0;
        end
      end
      ST_DIFF: begin
        dx_nxt  = 33'(car_x_r) - 33'(rx_r);
        dy_nxt  = 33'(car_y_r) - 33'(ry_r);
        bax_nxt = clamp_abs(33'(car_x_r) - 33'(rx_r));
        bay_nxt = clamp_abs(33'(car_y_r) - 33'(ry_r));
      end
      ST_SQR: begin
      end
      ST_GOAL: begin
        goal_nxt = (dsum <= GOAL_D2_MAX);
        ang_nxt  = '0;
        if (dsum <= GOAL_D2_MAX) len_nxt = '0;
      end
      ST_ROT: begin
        m1_nxt = hc_r * dx_r;
        m2_nxt = hs_r * dy_r;
        m3_nxt = hc_r * dy_r;
        m4_nxt = hs_r * dx_r;
      end
      ST_RND: begin
        lxm_nxt = rnd_x[30:0];
        lym_nxt = rnd_y[30:0];
        lyn_nxt = rnd_y[31];
      end
      ST_CSQ: begin
        sqx_nxt = lxm_r * lxm_r;
        sqy_nxt = lym_r * lym_r;
        p_nxt   = lym_r * cfg.max_ang;
      end
      ST_CURV: begin
        ang_nxt = '0;
        if (dsum > CURV_D2_MIN) div_start = 1'b1;
      end
      ST_DIV: begin
        if (div_done) ang_nxt = div_quo;
      end
      ST_OUT: begin
        if (out_free) begin
          res_valid_nxt = 1'b1;
          res_nxt.linear  = goal_r ? '0 : cfg.max_lin;
          res_nxt.angular = ang_r;
          res_nxt.goal    = goal_r;
          res_nxt.cx      = car_x_r;
          res_nxt.cy      = car_y_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rx_r <= rx_nxt;   ry_r <= ry_nxt;   hc_r <= hc_nxt;   hs_r <= hs_nxt;
    l2_r <= l2_nxt;   rd_idx_r <= rd_idx_nxt;
    la_r <= la_nxt;   lb_r <= lb_nxt;   lc_r <= lc_nxt;
    bx_r <= bx_nxt;   by_r <= by_nxt;   cpx_r <= cpx_nxt; cpy_r <= cpy_nxt;
    bax_r <= bax_nxt; bay_r <= bay_nxt; sqx_r <= sqx_nxt; sqy_r <= sqy_nxt;
    car_x_r <= car_x_nxt; car_y_r <= car_y_nxt;
    dx_r <= dx_nxt;   dy_r <= dy_nxt;
    m1_r <= m1_nxt;   m2_r <= m2_nxt;   m3_r <= m3_nxt;   m4_r <= m4_nxt;
    lxm_r <= lxm_nxt; lym_r <= lym_nxt; lyn_r <= lyn_nxt;
    p_r <= p_nxt;     ang_r <= ang_nxt; goal_r <= goal_nxt; first_r <= first_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      issue_r     <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      issue_r     <= issue_nxt;
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      vc_r        <= vc_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// File: design/pure_pursuit_steering_top.sv
// pure_pursuit_steering_top: pure pursuit steering block, stream in and out
// depends on pps_pkg, pps_front and pps_back
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    in_tdata 160b, in_tuser 2b
//  out_     out  out_tvalid/out_tready  out_tdata 120b, out_tuser 1b
//  cfg_     in   cfg_we                 cfg_index 2b, cfg_wdata 24b
//
// a load passes through the queue and the back end writes it into the path store
// a tick scans the path from its end, then takes the difference, square and goal test;
// at the goal it goes to the output, off the goal it rotates, rounds and squares, and
// runs the bit-serial divider when the carrot is not too close
// a two-entry queue lets the input side take up to two items while a tick is at work
// reset clears the path length and handshakes and loads the config reset values; no clearing pass

module pure_pursuit_steering_top #(
  parameter int PATH_DEPTH = pps_pkg::PATH_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_x, point_y, robot_x, robot_y, heading_cos, heading_sin
  input  logic [159:0]                    in_tdata,
  // req_type, path_first
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // linear_cmd, angular_cmd, carrot_x, carrot_y
  output logic [119:0]                    out_tdata,
  // goal_reached
  output logic [0:0]                      out_tuser,
  input  logic                            cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pps_pkg::CFG_W-1:0]       cfg_wdata
);
  import pps_pkg::*;

  cfg_t    cfg_r;
  cmd_t    q_cmd;
  logic    q_valid, q_pop;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lookahead <= LOOKAHEAD_RST;
      cfg_r.max_lin   <= MAX_LIN_RST;
      cfg_r.max_ang   <= MAX_ANG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOOKAHEAD: cfg_r.lookahead <= cfg_wdata;
        REG_MAX_LIN:   cfg_r.max_lin   <= cfg_wdata;
        REG_MAX_ANG:   cfg_r.max_ang   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  pps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_user (in_tuser),
    .in_data (in_tdata),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  pps_back #(
    .PATH_DEPTH(PATH_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res)
  );

  assign out_tdata = {res.cy, res.cx, res.angular, res.linear};
  assign out_tuser = res.goal;

endmodule

// File: bench/pps_checker.sv
// pps_checker: watches the item, result and register ports of the pure pursuit block,
// predicts each steering command and compares it field by field
// depends on pps_pkg for the register codes, reset values, distance limits and result layout

module pps_checker #(
  parameter int PATH_DEPTH = pps_pkg::PATH_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [159:0]                  in_tdata,
  input  logic [1:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [119:0]                  out_tdata,
  input  logic [0:0]                    out_tuser,
  input  logic                          cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pps_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            mismatches,
  output int                            pending,
  output int                            goals
);
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam longint unsigned MAG_MAX = 64'd2147483647;

  cfg_t                regs;
  logic signed [31:0]  path_x [PATH_DEPTH];
  logic signed [31:0]  path_y [PATH_DEPTH];
  int                  path_n;
  result_t             cmd_q [$];

  function automatic longint unsigned mag31(longint v);
    longint unsigned a;
    a = (v < 0) ? -v : v;
    return (a > MAG_MAX) ? MAG_MAX : a;
  endfunction

  function automatic longint unsigned span2(longint dx, longint dy);
    longint unsigned ax, ay;
    ax = mag31(dx);
    ay = mag31(dy);
    return ax * ax + ay * ay;
  endfunction

  // drop the q1.14 scale, half away from zero, then clamp
  function automatic longint round_q14(longint v);
    longint r;
    if (v >= 0) r = (v + 8192) >>> 14;
    else r = -((-v + 8192) >>> 14);
    if (r > longint'(MAG_MAX)) r = MAG_MAX;
    if (r < -longint'(MAG_MAX)) r = -longint'(MAG_MAX);
    return r;
  endfunction

  // 2*y*gain*2^16 / d, truncated toward zero, saturated to 32 bits
  function automatic longint turn_rate(longint ly, longint unsigned d);
    bit neg;
    longint unsigned a, p, q, r, lim;
    neg = ly < 0;
    a = neg ? -ly : ly;
    p = a * longint'(regs.max_ang);
    q = p / d;
    r = p % d;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (q >= lim) return neg ? -longint'(lim) : longint'(lim);
    for (int i = 0; i < 17; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
      if (q >= lim) begin
        q = lim;
        break;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_tick(logic signed [31:0] rx, logic signed [31:0] ry,
                              logic signed [15:0] hc, logic signed [15:0] hs);
    longint unsigned reach2, d2, dl;
    longint dx, dy, lx, ly;
    int sel;
    result_t e;
    if (path_n == 0) return;
    reach2 = longint'(regs.lookahead) * longint'(regs.lookahead);
    sel = path_n - 1;
    for (int i = path_n - 1; i >= 0; i--) begin
      if (span2(longint'(path_x[i]) - rx, longint'(path_y[i]) - ry) > reach2) sel = i;
      else break;
    end
    dx = longint'(path_x[sel]) - longint'(rx);
    dy = longint'(path_y[sel]) - longint'(ry);
    e.cx = path_x[sel];
    e.cy = path_y[sel];
    d2 = span2(dx, dy);
    if (d2 <= GOAL_D2_MAX) begin
      path_n = 0;
      e.linear = '0;
      e.angular = '0;
      e.goal = 1'b1;
    end else begin
      lx = round_q14(longint'(hc) * dx + longint'(hs) * dy);
      ly = round_q14(longint'(hc) * dy - longint'(hs) * dx);
      dl = span2(lx, ly);
      e.linear = regs.max_lin;
      e.angular = (dl > CURV_D2_MIN) ? 32'(turn_rate(ly, dl)) : '0;
      e.goal = 1'b0;
    end
    cmd_q.push_back(e);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      regs.lookahead <= LOOKAHEAD_RST;
      regs.max_lin <= MAX_LIN_RST;
      regs.max_ang <= MAX_ANG_RST;
      path_n = 0;
      cmd_q.delete();
      mismatches <= 0;
      pending <= 0;
      goals <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOOKAHEAD: regs.lookahead <= cfg_wdata;
          REG_MAX_LIN:   regs.max_lin <= cfg_wdata;
          REG_MAX_ANG:   regs.max_ang <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.linear = out_tdata[23:0];
        got.angular = out_tdata[55:24];
        got.cx = out_tdata[87:56];
        got.cy = out_tdata[119:88];
        got.goal = out_tuser[0];
        if (cmd_q.size() == 0) begin
          $error("steering command with none expected");
          mismatches <= mismatches + 1;
        end else begin
          want = cmd_q.pop_front();
          if (got.goal) goals <= goals + 1;
          if (got != want) mismatches <= mismatches + 1;
          if (got.linear != want.linear)
            $error("linear_cmd expected %0d got %0d", want.linear, got.linear);
          if (got.angular != want.angular)
            $error("angular_cmd expected %0d got %0d", want.angular, got.angular);
          if (got.goal != want.goal)
            $error("goal_reached expected %0d got %0d", want.goal, got.goal);
          if (got.cx != want.cx)
            $error("carrot_x expected %0d got %0d", want.cx, got.cx);
          if (got.cy != want.cy)
            $error("carrot_y expected %0d got %0d", want.cy, got.cy);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0]) begin
          predict_tick(in_tdata[95:64], in_tdata[127:96], in_tdata[143:128],
                       in_tdata[159:144]);
        end else begin
          if (in_tuser[1]) path_n = 0;
          if (path_n < PATH_DEPTH) begin
            path_x[path_n] = in_tdata[31:0];
            path_y[path_n] = in_tdata[63:32];
            path_n++;
          end
        end
      end
      pending <= cmd_q.size();
    end
  end

endmodule

// File: bench/tb.sv
// tb: stimulus and verdict for pure_pursuit_steering_top
// path loads, pose ticks and register settings; pps_checker does the prediction

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 1200;

  // q1.14 heading values
  localparam logic [15:0] H_ONE   = 16'h4000;
  localparam logic [15:0] H_NEG   = 16'hC000;
  localparam logic [15:0] H_ZERO  = 16'h0000;
  localparam logic [15:0] H_DIAG  = 16'h2D41;
  localparam logic [15:0] H_NDIAG = 16'hD2BF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [159:0]         in_tdata = '0;
  logic [1:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [119:0]         out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int  mismatches, pending, goals;
  int  stall_cycles = 0;
  int  hold_reqs = 0, hold_seen = 0, hold_left = 0;
  bit  no_idle = 0;
  int  n_loads = 0, n_ticks = 0, n_settings = 1;

  pure_pursuit_steering_top u_top (.*);

  pps_checker u_chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 37);
    end
  end

  task automatic send(input logic [1:0] u, input logic [159:0] d);
    if (!no_idle && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= u;
    do @(posedge clk); while (!in_tready);
  endtask

  // unused fields of an item carry random bits
  task automatic load_pt(input bit first, input logic [31:0] x, input logic [31:0] y);
    send({first, 1'b0}, {$urandom, $urandom, $urandom, y, x});
    n_loads++;
  endtask

  task automatic tick(input logic [31:0] rx, input logic [31:0] ry,
                      input logic [15:0] hc, input logic [15:0] hs);
    send({1'($urandom), 1'b1}, {hs, hc, ry, rx, $urandom, $urandom});
    n_ticks++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] la, input logic [CFG_W-1:0] lin,
                            input logic [CFG_W-1:0] ang);
    cfg_we <= 1'b1;
    cfg_index <= REG_LOOKAHEAD;
    cfg_wdata <= la;
    @(posedge clk);
    cfg_index <= REG_MAX_LIN;
    cfg_wdata <= lin;
    @(posedge clk);
    cfg_index <= REG_MAX_ANG;
    cfg_wdata <= ang;
    @(posedge clk);
    // unmapped index must leave everything alone
    cfg_index <= REG_SPARE;
    cfg_wdata <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic rand_heading(output logic [15:0] hc, output logic [15:0] hs);
    real a;
    if ($urandom_range(9) == 0) begin
      hc = 16'($signed($urandom_range(32768)) - 16384);
      hs = 16'($signed($urandom_range(32768)) - 16384);
    end else begin
      a = $urandom_range(6283) / 1000.0;
      hc = 16'($rtoi($cos(a) * 16384.0));
      hs = 16'($rtoi($sin(a) * 16384.0));
    end
  endtask

  initial begin
    longint    wx [16];
    longint    wy [16];
    longint    px, py;
    real       dir;
    int        len, sent, j, ph, quota;
    logic [15:0] hc, hs;
    logic [CFG_W-1:0] la_set [5];
    logic [CFG_W-1:0] lin_set [5];
    logic [CFG_W-1:0] ang_set [5];

    la_set = '{LOOKAHEAD_RST, 24'd0, 24'hFFFFFF, 24'd52429, 24'd0};
    lin_set = '{MAX_LIN_RST, 24'd0, 24'hFFFFFF, 24'd32768, 24'd0};
    ang_set = '{MAX_ANG_RST, 24'd0, 24'hFFFFFF, 24'd131072, 24'd0};
    la_set[4] = CFG_W'($urandom_range(16000, 120000));
    lin_set[4] = CFG_W'($urandom);
    ang_set[4] = CFG_W'($urandom_range(1, 400000));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty path, then far coordinates and extreme headings
    tick(0, 0, H_ONE, H_ZERO);
    load_pt(1'b1, 32'h80000000, 32'h7FFFFFFF);
    tick(0, 0, H_ONE, H_ZERO);
    tick(32'h7FFFFFFF, 32'h80000000, H_NEG, H_NEG);
    tick(32'h80000000, 32'h80000000, H_ONE, H_ONE);
    // short path, straight at the start then bending
    load_pt(1'b1, 0, 0);
    load_pt(1'b0, 19661, 0);
    load_pt(1'b0, 39322, 0);
    load_pt(1'b0, 65536, 6554);
    load_pt(1'b0, 131072, -13107);
    tick(0, 0, H_ONE, H_ZERO);
    tick(0, 0, H_ZERO, H_ONE);
    tick(0, 0, H_ZERO, H_ZERO);
    tick(-65536, -65536, H_DIAG, H_NDIAG);
    tick(133072, -14107, H_ONE, H_ZERO);
    tick(0, 0, H_ONE, H_ZERO);
    // either side of the goal radius
    load_pt(1'b1, 0, 0);
    tick(6554, 0, H_ONE, H_ZERO);
    tick(6553, 0, H_ONE, H_ZERO);

    // fill the store past its depth; the tail is dropped
    for (int i = 0; i < PATH_DEPTH_DEF + 6; i++) load_pt(i == 0, i * 4096, 0);
    tick(-1310720, 0, H_ONE, H_ZERO);
    tick(512 * 4096, 30000, H_ONE, H_ZERO);
    tick(1023 * 4096, 0, H_ONE, H_ZERO);

    for (ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        write_regs(la_set[ph], lin_set[ph], ang_set[ph]);
      end
      no_idle = (ph == 1);
      if (ph == 2) begin
        load_pt(1'b1, 0, 0);
        load_pt(1'b0, 30000, 20000);
        hold_reqs++;
        for (int i = 0; i < 8; i++) begin
          tick(-$urandom_range(20000), $urandom_range(20000), H_ONE, H_ZERO);
        end
      end
      quota = 90;
      sent = 0;
      while (sent < quota) begin
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1)) load_pt(1'($urandom_range(1)), $urandom, $urandom);
          else tick($urandom, $urandom, 16'($signed($urandom_range(32768)) - 16384),
                    16'($signed($urandom_range(32768)) - 16384));
          sent++;
        end else begin
          len = $urandom_range(1, 12);
          px = longint'($urandom_range(655360)) - 327680;
          py = longint'($urandom_range(655360)) - 327680;
          dir = $urandom_range(6283) / 1000.0;
          for (int i = 0; i < len; i++) begin
            wx[i] = px;
            wy[i] = py;
            load_pt(i == 0, 32'(px), 32'(py));
            dir = dir + ($signed($urandom_range(1000)) - 500) / 1000.0;
            px = px + $rtoi($urandom_range(3000, 30000) * $cos(dir));
            py = py + $rtoi($urandom_range(3000, 30000) * $sin(dir));
          end
          sent += len;
          for (int i = $urandom_range(1, 6); i > 0; i--) begin
            rand_heading(hc, hs);
            if ($urandom_range(4) == 0) begin
              tick(32'(wx[len-1] + $signed($urandom_range(6000)) - 3000),
                   32'(wy[len-1] + $signed($urandom_range(6000)) - 3000), hc, hs);
            end else begin
              j = $urandom_range(len - 1);
              tick(32'(wx[j] + $signed($urandom_range(40000)) - 20000),
                   32'(wy[j] + $signed($urandom_range(40000)) - 20000), hc, hs);
            end
            sent++;
          end
        end
      end
    end

    drain();
    $display("covered %0d path loads and %0d ticks under %0d register settings, %0d goals",
             n_loads, n_ticks, n_settings, goals);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
